>>> rtl/dtod_pkg.sv
// ----------------------------------------------------------------------------
// dtod_pkg: shared types and constants
// Widths of the item fields, register indexes and usage codes of the detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dtod_pkg;

    localparam int SEND_W    = 32;
    localparam int ARRIVAL_W = 48;
    localparam int BYTES_W   = 16;
    localparam int USAGE_W   = 2;
    localparam int EFF_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [USAGE_W-1:0]   usage_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam usage_t USAGE_NORMAL = 2'd0;
    localparam usage_t USAGE_WEAK   = 2'd1;
    localparam usage_t USAGE_OVER   = 2'd2;

    localparam cfg_idx_t REG_DECAY_DIV   = 3'd0;
    localparam cfg_idx_t REG_STRONG_THR  = 3'd1;
    localparam cfg_idx_t REG_WEAK_THR    = 3'd2;
    localparam cfg_idx_t REG_OVERUSE_MS  = 3'd3;
    localparam cfg_idx_t REG_BITRATE     = 3'd4;
    localparam cfg_idx_t REG_JITTER_WIN  = 3'd5;

endpackage

`default_nettype wire

>>> rtl/dtod_if.sv
// ----------------------------------------------------------------------------
// dtod_if: channel interfaces
// Packet input, result output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtod_pkt_if;
    logic                          valid;
    logic                          ready;
    logic [dtod_pkg::SEND_W-1:0]    send_time_ms;
    logic [dtod_pkg::ARRIVAL_W-1:0] arrival_time_ms;
    logic [dtod_pkg::BYTES_W-1:0]   packet_bytes;
    modport source (output valid, send_time_ms, arrival_time_ms, packet_bytes, input ready);
    modport sink   (input valid, send_time_ms, arrival_time_ms, packet_bytes, output ready);
endinterface

interface dtod_res_if;
    logic                          valid;
    logic                          ready;
    logic [dtod_pkg::USAGE_W-1:0]   usage;
    logic signed [dtod_pkg::EFF_W-1:0] effective_trend_q8;
    modport source (output valid, usage, effective_trend_q8, input ready);
    modport sink   (input valid, usage, effective_trend_q8, output ready);
endinterface

interface dtod_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dtod_pkg::CFG_IDX_W-1:0]  index;
    logic [dtod_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/delay_trend_overuse_detector.sv
// ----------------------------------------------------------------------------
// delay_trend_overuse_detector: delay-trend bandwidth overuse detector
// Decaying delay trend less window jitter and size delay, judged against
// strong and weak thresholds.
// ----------------------------------------------------------------------------
// Use: one packet item in on pkt (send time, arrival time, size), one result
// item out on res (usage, effective trend). Registers are written on cfg, which
// is always ready; write them only while the block is idle.
// One packet is handled at a time; pkt.ready is high only in the idle state.
// A first packet goes from acceptance straight to the done state, one with
// invalid deltas through the check state first. Other packets pass one 48-step
// shift-subtract divider for the trend decay and, when the bitrate is set and
// the size grew, again for the size delay; they age the window with a read and
// a check per dropped entry and scan the live entries at one memory read a cycle.
// The result sits in an output register; the next packet is accepted while it
// waits, and the block holds its finished result if res stalls.
// After reset (rst_n low) the control and config registers take reset values,
// the window is empty and the next packet primes. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module delay_trend_overuse_detector #(
    parameter int WINDOW_DEPTH = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dtod_pkt_if.sink    pkt,
    dtod_res_if.source  res,
    dtod_cfg_if.sink    cfg
);

    localparam int PW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C  = WINDOW_DEPTH[CW-1:0];
    localparam logic [CW:0]   DEPTH_C1 = WINDOW_DEPTH[CW:0];
    localparam logic [PW-1:0] LAST_IDX = PW'(WINDOW_DEPTH - 1);
    localparam logic signed [58:0] TREND_MAX = 59'sd549755813887;
    localparam logic signed [58:0] TREND_MIN = -59'sd549755813888;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_CHECK   = 11'b000_0000_0010,
        S_DIV     = 11'b000_0000_0100,
        S_TREND   = 11'b000_0000_1000,
        S_PUSH    = 11'b000_0001_0000,
        S_AGE_RD  = 11'b000_0010_0000,
        S_AGE_CHK = 11'b000_0100_0000,
        S_SCAN    = 11'b000_1000_0000,
        S_SIZE    = 11'b001_0000_0000,
        S_SDIV    = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [15:0]        decay_reg;
    logic signed [23:0] strong_reg;
    logic signed [23:0] weak_reg;
    logic [15:0]        over_ms_reg;
    logic [31:0]        bitrate_reg;
    logic [15:0]        jwin_reg;

    // detector state
    logic               primed_reg;
    logic [31:0]        last_send_reg;
    logic [47:0]        last_arr_reg;
    logic [15:0]        last_bytes_reg;
    logic signed [39:0] trend_reg;
    logic [31:0]        elapsed_reg;
    logic [PW-1:0]      head_reg;
    logic [CW-1:0]      count_reg;

    // per-packet work registers
    logic [31:0]        sd_reg;
    logic [48:0]        ad_reg;
    logic [47:0]        arr_reg;
    logic               grow_reg;
    logic [15:0]        growth_reg;
    logic signed [49:0] dd_reg;
    logic [31:0]        jit_reg;
    logic               neg_reg;
    logic [31:0]        best_reg;
    logic               zero_res_reg;
    logic               size_use_reg;
    logic [PW-1:0]      scan_ptr_reg;
    logic [CW-1:0]      scan_left_reg;
    logic               rd_vld_reg;
    logic [47:0]        rd_time_reg;
    logic [31:0]        rd_jit_reg;

    // shared divider
    logic [32:0]        div_rem_reg;
    logic [47:0]        div_quo_reg;
    logic [31:0]        div_den_reg;
    logic [5:0]         div_cnt_reg;

    // output register
    logic               out_valid_reg;
    logic [1:0]         out_usage_reg;
    logic signed [31:0] out_eff_reg;

    // window memories
    logic [47:0]        time_mem [WINDOW_DEPTH];
    logic [31:0]        jit_mem  [WINDOW_DEPTH];

    logic               pkt_acc;
    logic               out_load;
    logic [32:0]        rem_sh;
    logic [33:0]        rem_diff;
    logic               div_last;
    logic signed [47:0] trend_x256;
    logic [47:0]        trend_mag;
    logic signed [48:0] trend_q;
    logic signed [58:0] trend_sum;
    logic [49:0]        dd_abs;
    logic [PW-1:0]      head_eff;
    logic [CW-1:0]      cnt_eff;
    logic [CW:0]        wr_sum;
    logic [PW-1:0]      wr_idx;
    logic               wr_en;
    logic [PW-1:0]      head_inc;
    logic signed [48:0] age;
    logic signed [41:0] eff;
    logic [36:0]        size_q8;
    logic [36:0]        size_num;
    logic [48:0]        el_sum;
    logic [31:0]        el_new;
    logic signed [41:0] eff_wide;
    logic signed [31:0] eff_sat;
    logic [1:0]         usage_new;
    logic               above;

    assign pkt.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign pkt_acc   = pkt.valid && pkt.ready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || res.ready);

    assign res.valid              = out_valid_reg;
    assign res.usage              = out_usage_reg;
    assign res.effective_trend_q8 = out_eff_reg;

    // divider step
    assign rem_sh   = {div_rem_reg[31:0], div_quo_reg[47]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, div_den_reg};
    assign div_last = (div_cnt_reg == 6'd47);

    assign trend_x256 = {trend_reg, 8'b0};
    assign trend_mag  = trend_x256[47] ? 48'(-trend_x256) : 48'(trend_x256);
    assign trend_q    = neg_reg ? -$signed({1'b0, div_quo_reg}) : $signed({1'b0, div_quo_reg});
    assign trend_sum  = 59'(trend_q) + 59'($signed({dd_reg, 8'b0}));
    assign dd_abs     = dd_reg[49] ? 50'(-dd_reg) : 50'(dd_reg);

    // window pointers
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_eff = (count_reg == DEPTH_C) ? head_inc : head_reg;
    assign cnt_eff  = (count_reg == DEPTH_C) ? count_reg - 1'b1 : count_reg;
    assign wr_sum   = {1'b0, CW'(head_eff)} + {1'b0, cnt_eff};
    assign wr_idx   = (wr_sum >= DEPTH_C1) ? PW'(wr_sum - DEPTH_C1) : PW'(wr_sum);
    assign wr_en    = (state_reg == S_PUSH);
    assign age      = $signed({1'b0, arr_reg}) - $signed({1'b0, rd_time_reg});

    // result
    assign size_num = 37'(growth_reg) * 37'd2048000;
    assign size_q8  = size_use_reg ? div_quo_reg[36:0] : '0;
    assign eff      = 42'(trend_reg) - $signed({10'b0, jit_reg}) - $signed({5'b0, size_q8})
                      + 42'(0) - $signed({10'b0, best_reg}) + $signed({10'b0, jit_reg});
    assign eff_wide = eff;
    assign above    = eff_wide > 42'(strong_reg);
    assign el_sum   = {17'b0, elapsed_reg} + {1'b0, ad_reg[47:0]};
    assign el_new   = (el_sum[48:32] != '0) ? 32'hFFFF_FFFF : el_sum[31:0];
    assign eff_sat  = (eff_wide > 42'sd2147483647) ? 32'sh7FFF_FFFF :
                      (eff_wide < -42'sd2147483648) ? 32'sh8000_0000 : 32'(eff_wide);

    always_comb
    begin
        priority if (above)
        begin
            usage_new = (el_new >= {16'b0, over_ms_reg}) ? dtod_pkg::USAGE_OVER
                                                         : dtod_pkg::USAGE_WEAK;
        end
        else
        begin
            usage_new = (eff_wide > 42'(weak_reg)) ? dtod_pkg::USAGE_WEAK
                                                  : dtod_pkg::USAGE_NORMAL;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (pkt_acc) state_next = primed_reg ? S_CHECK : S_DONE;
            S_CHECK:   state_next = ($signed(sd_reg) <= 0 || ad_reg[48]) ? S_DONE : S_DIV;
            S_DIV:     if (div_last) state_next = S_TREND;
            S_TREND:   state_next = S_PUSH;
            S_PUSH:    state_next = S_AGE_RD;
            S_AGE_RD:  state_next = S_AGE_CHK;
            S_AGE_CHK: state_next = (count_reg != '0 && age > $signed({33'b0, jwin_reg}))
                                    ? S_AGE_RD : S_SCAN;
            S_SCAN:    if (scan_left_reg == '0 && !rd_vld_reg) state_next = S_SIZE;
            S_SIZE:    state_next = (bitrate_reg != '0 && grow_reg) ? S_SDIV : S_DONE;
            S_SDIV:    if (div_last) state_next = S_DONE;
            S_DONE:    if (out_load) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            decay_reg      <= 16'd256;
            strong_reg     <= 24'sd3200;
            weak_reg       <= 24'sd1280;
            over_ms_reg    <= 16'd10;
            bitrate_reg    <= '0;
            jwin_reg       <= 16'd500;
            primed_reg     <= 1'b0;
            last_send_reg  <= '0;
            last_arr_reg   <= '0;
            last_bytes_reg <= '0;
            trend_reg      <= '0;
            elapsed_reg    <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            rd_vld_reg     <= 1'b0;
            scan_left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    dtod_pkg::REG_DECAY_DIV:  decay_reg   <= cfg.data[15:0];
                    dtod_pkg::REG_STRONG_THR: strong_reg  <= cfg.data[23:0];
                    dtod_pkg::REG_WEAK_THR:   weak_reg    <= cfg.data[23:0];
                    dtod_pkg::REG_OVERUSE_MS: over_ms_reg <= cfg.data[15:0];
                    dtod_pkg::REG_BITRATE:    bitrate_reg <= cfg.data;
                    dtod_pkg::REG_JITTER_WIN: jwin_reg    <= cfg.data[15:0];
                    default: ;
                endcase
            end

            if (pkt_acc)
            begin
                primed_reg     <= 1'b1;
                last_send_reg  <= pkt.send_time_ms;
                last_arr_reg   <= pkt.arrival_time_ms;
                last_bytes_reg <= pkt.packet_bytes;
            end

            if (state_reg == S_TREND)
            begin
                priority if (trend_sum > TREND_MAX)
                    trend_reg <= TREND_MAX[39:0];
                else if (trend_sum < TREND_MIN)
                    trend_reg <= TREND_MIN[39:0];
                else
                    trend_reg <= trend_sum[39:0];
            end

            if (state_reg == S_PUSH)
            begin
                head_reg  <= head_eff;
                count_reg <= cnt_eff + 1'b1;
            end

            // drop the oldest entry while it is too old
            if (state_reg == S_AGE_CHK && state_next == S_AGE_RD)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end

            if (state_reg == S_AGE_CHK && state_next == S_SCAN)
            begin
                scan_left_reg <= count_reg;
                rd_vld_reg    <= 1'b0;
            end
            else if (state_reg == S_SCAN && scan_left_reg != '0)
            begin
                scan_left_reg <= scan_left_reg - 1'b1;
                rd_vld_reg    <= 1'b1;
            end
            else
            begin
                rd_vld_reg <= 1'b0;
            end

            if (out_load && !zero_res_reg)
                elapsed_reg <= above ? el_new : '0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        if (pkt_acc)
        begin
            sd_reg       <= pkt.send_time_ms - last_send_reg;
            ad_reg       <= {1'b0, pkt.arrival_time_ms} - {1'b0, last_arr_reg};
            arr_reg      <= pkt.arrival_time_ms;
            grow_reg     <= pkt.packet_bytes > last_bytes_reg;
            growth_reg   <= pkt.packet_bytes - last_bytes_reg;
            zero_res_reg <= !primed_reg;
            size_use_reg <= 1'b0;
        end

        unique case (state_reg)
            S_CHECK:
            begin
                zero_res_reg <= ($signed(sd_reg) <= 0 || ad_reg[48]);
                dd_reg       <= $signed({ad_reg[48], ad_reg}) - 50'($signed(sd_reg));
                neg_reg      <= trend_x256[47];
                div_rem_reg  <= '0;
                div_quo_reg  <= trend_mag;
                div_den_reg  <= (decay_reg < 16'd256) ? 32'd256 : {16'b0, decay_reg};
                div_cnt_reg  <= '0;
            end
            S_DIV, S_SDIV:
            begin
                if (!rem_diff[33])
                begin
                    div_rem_reg <= rem_diff[32:0];
                    div_quo_reg <= {div_quo_reg[46:0], 1'b1};
                end
                else
                begin
                    div_rem_reg <= rem_sh;
                    div_quo_reg <= {div_quo_reg[46:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            S_TREND:
            begin
                jit_reg <= (dd_abs[49:23] != '0) ? 32'h7FFF_FFFF : {dd_abs[23:0], 8'b0};
            end
            S_AGE_CHK:
            begin
                scan_ptr_reg <= head_reg;
                best_reg     <= '0;
            end
            S_SCAN:
            begin
                if (scan_left_reg != '0)
                    scan_ptr_reg <= (scan_ptr_reg == LAST_IDX) ? '0 : scan_ptr_reg + 1'b1;
                if (rd_vld_reg && rd_jit_reg > best_reg)
                    best_reg <= rd_jit_reg;
            end
            S_SIZE:
            begin
                size_use_reg <= (bitrate_reg != '0 && grow_reg);
                div_rem_reg  <= '0;
                div_quo_reg  <= {11'b0, size_num};
                div_den_reg  <= bitrate_reg;
                div_cnt_reg  <= '0;
            end
            default: ;
        endcase

        if (out_load)
        begin
            out_usage_reg <= zero_res_reg ? dtod_pkg::USAGE_NORMAL : usage_new;
            out_eff_reg   <= zero_res_reg ? '0 : eff_sat;
        end
    end

    // window store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_idx] <= arr_reg;
            jit_mem[wr_idx]  <= jit_reg;
        end
        rd_time_reg <= time_mem[head_reg];
        rd_jit_reg  <= jit_mem[scan_ptr_reg];
    end

endmodule

`default_nettype wire
